// File: sv/bitmap_slot_allocator_assert.svh
// Assertion macros for the bitmap slot allocator.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSA_ASSERT_NEVER(lbl, prop, msg) `BSA_ASSERT(lbl, !(prop), msg)
`else
`define BSA_ASSERT(lbl, prop, msg)
`define BSA_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

// File: sv/bsa_pkg.sv
// Shared types and codes for the bitmap slot allocator.
// No dependencies.
package bsa_pkg;

  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int USE_W    = 9;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE        = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } bsa_state_e;

endpackage

// File: sv/bitmap_slot_allocator.sv
// Bitmap slot allocator: free-slot bitmap in a word memory, scanned by a small sequencer.
// Depends on bsa_pkg and bitmap_slot_allocator_assert.svh.

// A request beat is taken when start is high and busy is low; each request gives one
// result beat, shown for exactly one cycle with done_o high, which the receiver must take.
// Allocate reads each bitmap word in a scan state and checks it in an eval state; busy
// stays high while it scans from one word up to MAP_WORDS words. Free steps one word per
// cycle to the slot's word, then reads and updates it in an eval state. A full pool or
// an out-of-range free answers without leaving idle, so busy stays low. For a scanned
// request the result appears in the same cycle that busy drops. The bitmap memory has a
// valid bit per word, so there is no clearing pass after reset.
module bitmap_slot_allocator #(
  parameter int SLOT_TOTAL = 256,
  parameter int MAP_WORDS  = 8,
  parameter int WORD_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_number_i,
  output logic                          done_o,
  output logic [bsa_pkg::STATUS_W-1:0]  status_o,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot_o,
  output logic [bsa_pkg::USE_W-1:0]     slots_in_use_o
);
  import bsa_pkg::*;
  `include "bitmap_slot_allocator_assert.svh"

  localparam int SPAN  = MAP_WORDS * WORD_BITS;
  localparam int LIM0  = (SPAN > SLOT_TOTAL) ? SPAN : SLOT_TOTAL;
  localparam int LIM   = (LIM0 > 256) ? LIM0 : 256;
  localparam int NUM_W = $clog2(LIM + 1);
  localparam int CNT_W = $clog2(SLOT_TOTAL + 1);
  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);

  bsa_state_e state_q, state_d;

  logic                 req_q, req_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [AW-1:0]        w_q, w_d;
  logic [NUM_W-1:0]     base_q, base_d;
  logic [BW-1:0]        bit_q, bit_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [SLOT_W-1:0]    granted_q, granted_d;

  // bitmap word store, one valid bit per word (invalid reads as all free)
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_vld_q;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [WORD_BITS-1:0] word_eff;
  logic [BW-1:0]        lsb;
  logic                 word_nz;
  logic [NUM_W-1:0]     slot_in_ext;
  logic [NUM_W-1:0]     slot_ext;
  logic [NUM_W:0]       base_nx;
  logic                 hit;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     diff;
  logic [BW-1:0]        bit_sel;
  logic [WORD_BITS-1:0] onehot;
  logic                 last_word;
  logic                 pool_full;
  logic                 in_oor;
  logic [CNT_W+USE_W-1:0] cnt_ext;

  assign word_eff    = rd_vld_q ? rd_q : '1;
  assign word_nz     = (word_eff != '0);
  assign slot_in_ext = NUM_W'(slot_number_i);
  assign slot_ext    = NUM_W'(slot_q);
  assign base_nx     = (NUM_W + 1)'(base_q) + (NUM_W + 1)'(WORD_BITS);
  assign hit         = ({1'b0, slot_ext} < base_nx);
  assign num         = base_q + NUM_W'(lsb);
  assign diff        = slot_ext - base_q;
  assign bit_sel     = (req_q == REQ_ALLOC) ? lsb : bit_q;
  assign onehot      = WORD_BITS'(1) << bit_sel;
  assign last_word   = (w_q == AW'(MAP_WORDS - 1));
  assign pool_full   = (cnt_q >= CNT_W'(SLOT_TOTAL));
  assign in_oor      = (slot_in_ext >= NUM_W'(SLOT_TOTAL)) || (slot_in_ext >= NUM_W'(SPAN));

  // lowest set bit of the word under test
  always_comb begin
    lsb = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_eff[i]) begin
        lsb = BW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_ALLOC) begin
            state_d = pool_full ? ST_IDLE : ST_SCAN;
          end else begin
            state_d = in_oor ? ST_IDLE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (req_q == REQ_ALLOC || hit) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (req_q == REQ_ALLOC && !word_nz && !last_word) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    req_d     = req_q;
    slot_d    = slot_q;
    w_d       = w_q;
    base_d    = base_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = granted_q;
    mem_we    = 1'b0;
    mem_wdata = word_eff;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d  = req_type_i;
          slot_d = slot_number_i;
          w_d    = '0;
          base_d = '0;
          if (req_type_i == REQ_ALLOC && pool_full) begin
            done_d    = 1'b1;
            status_d  = STAT_FULL;
            granted_d = '0;
          end else if (req_type_i == REQ_FREE && in_oor) begin
            done_d    = 1'b1;
            status_d  = STAT_RANGE;
            granted_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (req_q == REQ_FREE) begin
          if (hit) begin
            bit_d = diff[BW-1:0];
          end else begin
            w_d    = w_q + AW'(1);
            base_d = base_nx[NUM_W-1:0];
          end
        end
      end
      ST_EVAL: begin
        if (req_q == REQ_ALLOC) begin
          if (word_nz) begin
            done_d    = 1'b1;
            granted_d = '0;
            if (num < NUM_W'(SLOT_TOTAL)) begin
              mem_we    = 1'b1;
              mem_wdata = word_eff & ~onehot;
              cnt_d     = cnt_q + CNT_W'(1);
              status_d  = STAT_OK;
              granted_d = num[SLOT_W-1:0];
            end else begin
              status_d = STAT_FULL;
            end
          end else if (last_word) begin
            done_d    = 1'b1;
            status_d  = STAT_FULL;
            granted_d = '0;
          end else begin
            w_d    = w_q + AW'(1);
            base_d = base_nx[NUM_W-1:0];
          end
        end else begin
          done_d    = 1'b1;
          granted_d = '0;
          if (word_eff[bit_q]) begin
            status_d = STAT_ALREADY_FREE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = word_eff | onehot;
            status_d  = STAT_OK;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      req_q    <= REQ_ALLOC;
      w_q      <= '0;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      rd_vld_q <= vld_q[w_q];
      req_q    <= req_d;
      w_q      <= w_d;
      base_q   <= base_d;
      if (mem_we) begin
        vld_q[w_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    bit_q     <= bit_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // bitmap memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[w_q] <= mem_wdata;
    end
    rd_q <= mem[w_q];
  end

  assign cnt_ext        = {{USE_W{1'b0}}, cnt_q};
  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign slots_in_use_o = cnt_ext[USE_W-1:0];

  `BSA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(SLOT_TOTAL), "use count above slot total")
  `BSA_ASSERT(a_cnt_with_beat, cnt_q != $past(cnt_q) |-> done_o, "count moved without a result beat")
  `BSA_ASSERT(a_grant_ok, done_o && granted_slot_o != '0 |-> status_o == STAT_OK, "grant on failed request")
  `BSA_ASSERT_NEVER(a_scan_bound, w_q > AW'(MAP_WORDS - 1), "scan index past last word")

endmodule

// File: test/tb.sv
// Self-checking testbench for bitmap_slot_allocator: directed and random allocate/free beats,
// each checked against an in-bench model of the free-slot bitmap and the in-use count.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL.
module tb;
  import bsa_pkg::*;

  localparam int SLOT_TOTAL = 256;
  localparam int MAP_WORDS  = 8;
  localparam int WORD_BITS  = 32;
  localparam int RAND_ITEMS = 1130;
  localparam int MAX_SHOWN  = 10;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted;
    logic [USE_W-1:0]    in_use;
  } reply_t;

  // Tracks the bitmap as the block should hold it and the replies still owed.
  class alloc_scoreboard;
    logic [WORD_BITS-1:0] free_bits [MAP_WORDS];
    int unsigned          used_slots;
    reply_t               owed_replies [$];
    int unsigned          mismatches;

    function new();
      foreach (free_bits[i]) free_bits[i] = '1;
      used_slots = 0;
      mismatches = 0;
    endfunction

    function bit slot_open(int unsigned s);
      return free_bits[s / WORD_BITS][s % WORD_BITS];
    endfunction

    function void note_request(logic rt, logic [SLOT_W-1:0] sn);
      reply_t      r;
      int unsigned w;
      int unsigned b;
      int unsigned num;
      bit          found;
      r.status  = STAT_OK;
      r.granted = '0;
      if (rt == REQ_ALLOC) begin
        r.status = STAT_FULL;
        found    = 1'b0;
        if (used_slots < SLOT_TOTAL) begin
          for (w = 0; w < MAP_WORDS && !found; w++) begin
            if (free_bits[w] != '0) begin
              // scan stops at the first non-empty word, even if its bit is past the pool
              found = 1'b1;
              b = 0;
              while (!free_bits[w][b]) b++;
              num = w * WORD_BITS + b;
              if (num < SLOT_TOTAL) begin
                free_bits[w][b] = 1'b0;
                used_slots++;
                r.granted = num[SLOT_W-1:0];
                r.status  = STAT_OK;
              end
            end
          end
        end
      end else begin
        w = sn / WORD_BITS;
        b = sn % WORD_BITS;
        if (sn >= SLOT_TOTAL || w >= MAP_WORDS) begin
          r.status = STAT_RANGE;
        end else if (free_bits[w][b]) begin
          r.status = STAT_ALREADY_FREE;
        end else begin
          free_bits[w][b] = 1'b1;
          if (used_slots > 0) used_slots--;
        end
      end
      r.in_use = used_slots[USE_W-1:0];
      owed_replies.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] granted,
                               logic [USE_W-1:0] in_use);
      reply_t want;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result beat with no request outstanding: status %0d slot %0d use %0d",
                   $realtime, status, granted, in_use);
        return;
      end
      want = owed_replies.pop_front();
      if (status !== want.status || granted !== want.granted || in_use !== want.in_use) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: mismatch: status %0d/%0d slot %0d/%0d use %0d/%0d (expected/actual)",
                   $realtime, want.status, status, want.granted, granted, want.in_use, in_use);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [SLOT_W-1:0]   slot_number_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   granted_slot_o;
  logic [USE_W-1:0]    slots_in_use_o;

  alloc_scoreboard sb;

  bitmap_slot_allocator #(
    .SLOT_TOTAL(SLOT_TOTAL),
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .slot_number_i (slot_number_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .granted_slot_o(granted_slot_o),
    .slots_in_use_o(slots_in_use_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, granted_slot_o, slots_in_use_o);
  end

  // Idle for the given gap with junk on the fields, then present one beat until it is taken.
  task automatic send_req(input logic rt, input logic [SLOT_W-1:0] sn, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start         <= 1'b0;
      req_type_i    <= 1'($urandom);
      slot_number_i <= SLOT_W'($urandom);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= rt;
    slot_number_i <= sn;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(rt, sn);
  endtask

  initial begin
    phase_e            kind;
    int unsigned       sent;
    int unsigned       phase_len;
    int unsigned       alloc_pct;
    int unsigned       gap;
    int unsigned       roll;
    int unsigned       s;
    bit                quiet;
    bit                first;
    logic              rt;
    logic [SLOT_W-1:0] sn;

    sb            = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = REQ_ALLOC;
    slot_number_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first grants, reuse of the lowest hole, double frees, field extremes
    send_req(REQ_ALLOC, 8'h00, 0);
    send_req(REQ_ALLOC, 8'hFF, 0);
    send_req(REQ_ALLOC, 8'h00, 1);
    send_req(REQ_FREE,  8'h01, 0);
    send_req(REQ_FREE,  8'h01, 0);
    send_req(REQ_ALLOC, 8'h00, 2);
    send_req(REQ_FREE,  8'hFF, 0);
    send_req(REQ_FREE,  8'h00, 0);
    send_req(REQ_FREE,  8'h00, 1);
    send_req(REQ_ALLOC, 8'hAA, 0);
    send_req(REQ_ALLOC, 8'h55, 0);
    send_req(REQ_FREE,  8'hAA, 0);
    send_req(REQ_FREE,  8'h55, 3);
    send_req(REQ_FREE,  8'h02, 0);
    send_req(REQ_FREE,  8'h03, 0);
    send_req(REQ_ALLOC, 8'h00, 0);
    send_req(REQ_FREE,  8'h80, 0);
    send_req(REQ_FREE,  8'h7F, 0);
    send_req(REQ_ALLOC, 8'h00, 0);
    send_req(REQ_ALLOC, 8'h00, 0);

    // random phases; the first one fills the pool so full replies show up early
    sent  = 0;
    first = 1'b1;
    while (sent < RAND_ITEMS) begin
      kind      = first ? PH_FILL : phase_e'($urandom_range(0, 2));
      phase_len = first ? 300 : $urandom_range(20, 200);
      quiet     = ($urandom_range(0, 2) == 0);
      first     = 1'b0;
      case (kind)
        PH_FILL:  alloc_pct = 97;
        PH_DRAIN: alloc_pct = 15;
        default:  alloc_pct = 55;
      endcase
      for (int i = 0; i < phase_len && sent < RAND_ITEMS; i++) begin
        rt = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
        sn = SLOT_W'($urandom);
        if (rt == REQ_FREE && $urandom_range(0, 3) != 0) begin
          // mostly aim frees at slots that are actually held
          for (int k = 0; k < 16; k++) begin
            s = $urandom_range(0, SLOT_TOTAL - 1);
            if (!sb.slot_open(s)) break;
          end
          sn = s[SLOT_W-1:0];
        end
        if (quiet) begin
          gap = 0;
        end else begin
          roll = $urandom_range(0, 99);
          gap  = (roll < 60) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
        end
        send_req(rt, sn, gap);
        sent++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.owed_replies.size() != 0) @(posedge clk_i);
    repeat (2 * MAP_WORDS + 8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.owed_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bsa_pkg.sv
sv/bitmap_slot_allocator.sv
test/tb.sv
